### rtl/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

    // Widths fixed by the request and response formats.
    localparam int KEY_W  = 48;
    localparam int SLOT_W = 11;
    localparam int CNT_W  = 11;

    // Default table depth in slots.
    localparam int DEPTH_DEF = 1024;

    // Request kinds.
    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    // One incoming request.
    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } req_item_t;

    // One lookup response.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] position;
    } rsp_item_t;

    // Control that travels with a request down the search pipeline.
    typedef struct packed {
        logic valid;
        logic lookup;
        logic done;
    } stg_ctl_t;

endpackage

`default_nettype wire

### rtl/sorted_table_binary_search.sv
// Sorted key table with pipelined binary search. Software writes 48-bit keys
// in ascending order to slots 1 to entry_count with write requests, then
// sets entry_count through the configuration channel while the block is
// idle. A lookup request returns the matching slot, or found 0 and position 0
// when the key is absent, is zero, or entry_count is zero. The search is laid
// out as LEVELS = clog2(DEPTH+1) probe levels (11 for 1024 slots), each with
// its own copy of the table, so one request enters every cycle while no
// response is held. The stages are one entry stage, a read and a compare
// stage per level, and the response register. Writes travel through the
// same levels and update each copy in order, so a lookup always sees every
// write accepted before it. A stalled response freezes the whole pipeline,
// so req_stall follows rsp_stall while a response is held.
`default_nettype none

module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire req_item_t        req_data,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output rsp_item_t             rsp_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    localparam int SW     = $clog2(DEPTH + 1);
    localparam int BW     = SW + 1;
    localparam int LEVELS = $clog2(DEPTH + 1);

    logic             adv;
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      count_clamp;

    stg_ctl_t         ch_ctl  [LEVELS+1];
    req_item_t        ch_item [LEVELS+1];
    logic [BW-1:0]    ch_low  [LEVELS+1];
    logic [BW-1:0]    ch_high [LEVELS+1];
    logic [SW-1:0]    ch_pos  [LEVELS+1];

    stg_ctl_t         e_ctl_reg;
    req_item_t        e_item_reg;
    logic [BW-1:0]    e_high_reg;
    stg_ctl_t         e_ctl_next;

    logic             rsp_valid_reg;
    rsp_item_t        rsp_data_reg;

    // The whole pipeline moves unless a response is held.
    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;
    assign cfg_ready = 1'b1;

    // Entry count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // Entry stage: initial bounds and the early-out for a zero key or empty table.
    always_comb
    begin
        count_clamp = (32'(count_reg) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(count_reg);
        e_ctl_next.valid  = req_valid;
        e_ctl_next.lookup = (req_data.kind == KIND_LOOKUP);
        e_ctl_next.done   = (req_data.key == '0) || (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_ctl_reg <= '0;
        end
        else if (adv)
        begin
            e_ctl_reg <= e_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_item_reg <= req_data;
            e_high_reg <= count_clamp[BW-1:0];
        end
    end

    assign ch_ctl[0]  = e_ctl_reg;
    assign ch_item[0] = e_item_reg;
    assign ch_low[0]  = BW'(1);
    assign ch_high[0] = e_high_reg;
    assign ch_pos[0]  = '0;

    // Probe levels.
    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        stbs_level #(
            .DEPTH (DEPTH)
        ) u_level (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_ctl   (ch_ctl[g]),
            .in_item  (ch_item[g]),
            .in_low   (ch_low[g]),
            .in_high  (ch_high[g]),
            .in_pos   (ch_pos[g]),
            .out_ctl  (ch_ctl[g+1]),
            .out_item (ch_item[g+1]),
            .out_low  (ch_low[g+1]),
            .out_high (ch_high[g+1]),
            .out_pos  (ch_pos[g+1])
        );
    end

    // Response register: lookups only, writes end here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= ch_ctl[LEVELS].valid && ch_ctl[LEVELS].lookup;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_data_reg.found    <= (ch_pos[LEVELS] != '0);
            rsp_data_reg.position <= SLOT_W'(ch_pos[LEVELS]);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

### rtl/stbs_level.sv
`default_nettype none

// One probe level of the search: a private copy of the key table, a read
// stage that issues the probe at the midpoint, and a compare stage that
// narrows the bounds or records the match.
module stbs_level
    import stbs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire stg_ctl_t                     in_ctl,
    input  wire req_item_t                    in_item,
    input  wire logic [$clog2(DEPTH+1):0]     in_low,
    input  wire logic [$clog2(DEPTH+1):0]     in_high,
    input  wire logic [$clog2(DEPTH+1)-1:0]   in_pos,
    output stg_ctl_t                          out_ctl,
    output req_item_t                         out_item,
    output logic [$clog2(DEPTH+1):0]          out_low,
    output logic [$clog2(DEPTH+1):0]          out_high,
    output logic [$clog2(DEPTH+1)-1:0]        out_pos
);

    localparam int SW = $clog2(DEPTH + 1);
    localparam int BW = SW + 1;
    localparam int AW = $clog2(DEPTH);

    logic [KEY_W-1:0] mem [DEPTH];

    logic [BW:0]      mid_sum;
    logic [BW-1:0]    mid;
    logic [BW-1:0]    mid_m1;
    logic             active;
    logic [31:0]      slot_m1;
    logic             wr_en;

    stg_ctl_t         a_ctl_reg;
    logic             a_active_reg;
    req_item_t        a_item_reg;
    logic [BW-1:0]    a_low_reg;
    logic [BW-1:0]    a_high_reg;
    logic [SW-1:0]    a_pos_reg;
    logic [BW-1:0]    a_mid_reg;
    logic [KEY_W-1:0] rdata_reg;

    stg_ctl_t         b_ctl_reg;
    req_item_t        b_item_reg;
    logic [BW-1:0]    b_low_reg;
    logic [BW-1:0]    b_high_reg;
    logic [SW-1:0]    b_pos_reg;

    stg_ctl_t         b_ctl_next;
    logic [BW-1:0]    b_low_next;
    logic [BW-1:0]    b_high_next;
    logic [SW-1:0]    b_pos_next;

    // Midpoint of the current bounds and the probe address it selects.
    always_comb
    begin
        mid_sum = {1'b0, in_low} + {1'b0, in_high};
        mid     = mid_sum[BW:1];
        mid_m1  = mid - BW'(1);
        active  = in_ctl.valid && in_ctl.lookup && !in_ctl.done && (in_low <= in_high);
        slot_m1 = 32'(in_item.slot) - 32'd1;
        wr_en   = in_ctl.valid && !in_ctl.lookup && (in_item.slot != '0)
                  && (32'(in_item.slot) <= 32'(DEPTH));
    end

    // Table copy: a write request updates it as it passes, a lookup reads it.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wr_en)
            begin
                mem[slot_m1[AW-1:0]] <= in_item.key;
            end
            if (active)
            begin
                rdata_reg <= mem[mid_m1[AW-1:0]];
            end
        end
    end

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg    <= '0;
            a_active_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_ctl_reg    <= in_ctl;
            a_active_reg <= active;
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= in_item;
            a_low_reg  <= in_low;
            a_high_reg <= in_high;
            a_pos_reg  <= in_pos;
            a_mid_reg  <= mid;
        end
    end

    // Compare the probed key and narrow the bounds.
    always_comb
    begin
        b_ctl_next  = a_ctl_reg;
        b_low_next  = a_low_reg;
        b_high_next = a_high_reg;
        b_pos_next  = a_pos_reg;
        if (a_active_reg)
        begin
            if (a_item_reg.key < rdata_reg)
            begin
                b_high_next = a_mid_reg - BW'(1);
            end
            else if (a_item_reg.key == rdata_reg)
            begin
                b_pos_next      = a_mid_reg[SW-1:0];
                b_ctl_next.done = 1'b1;
            end
            else
            begin
                b_low_next = a_mid_reg + BW'(1);
            end
        end
    end

    // Compare stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
        end
        else if (adv)
        begin
            b_ctl_reg <= b_ctl_next;
        end
    end

    // Compare stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_item_reg <= a_item_reg;
            b_low_reg  <= b_low_next;
            b_high_reg <= b_high_next;
            b_pos_reg  <= b_pos_next;
        end
    end

    assign out_ctl  = b_ctl_reg;
    assign out_item = b_item_reg;
    assign out_low  = b_low_reg;
    assign out_high = b_high_reg;
    assign out_pos  = b_pos_reg;

endmodule

`default_nettype wire

### rtl/stbs_checker.sv
`default_nettype none

// Port-level checks for the sorted table search.
module stbs_checker
    import stbs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_stall,
    input wire req_item_t        req_data,
    input wire logic             rsp_valid,
    input wire logic             rsp_stall,
    input wire rsp_item_t        rsp_data,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready,
    input wire logic [CNT_W-1:0] cfg_data
);

    // A held response stays and keeps its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
        else $error("response changed while stalled");

    // A stalled request stays and keeps its value.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_stall) |=> (req_valid && $stable(req_data)))
        else $error("request changed while stalled");

    // Requests are held back exactly while a response is held.
    a_req_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall does not follow response backpressure");

    // A found key names a slot inside the table, a miss names none.
    a_rsp_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_data.found == (rsp_data.position != '0))
                       && (32'(rsp_data.position) <= 32'(DEPTH))))
        else $error("response position out of range");

    // The configuration channel never pushes back and takes a known count.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> (cfg_ready && !$isunknown(cfg_data)))
        else $error("configuration write refused");

endmodule

bind sorted_table_binary_search stbs_checker #(
    .DEPTH (DEPTH)
) u_stbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

`default_nettype wire
